// ===== rtl/sfq_pkg.sv =====
// Shared constants, field widths and codes for the SFQ/DRR packet scheduler.
// No dependencies.
`timescale 1ns / 1ps

package sfq_pkg;

  localparam int MAX_FLOWS_DEF  = 128;
  localparam int FLOW_DEPTH_DEF = 16;

  localparam int HASH_W  = 32;
  localparam int LEN_W   = 16;
  localparam int TAG_W   = 16;
  localparam int QUANT_W = 16;
  localparam int FC_W    = 8;
  localparam int LIM_W   = 5;
  localparam int DEF_W   = 18;
  localparam int FLOW_OW = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IW  = 2;

  // hash reduction: bits retired per cycle by the remainder unit
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = HASH_W / DIV_BITS;

  localparam logic [QUANT_W-1:0] QUANT_RST = 16'd1500;
  localparam logic [FC_W-1:0]    FC_RST    = 8'd128;
  localparam logic [LIM_W-1:0]   LIM_RST   = 5'd16;

  typedef enum logic [CFG_IW-1:0] {
    CFG_QUANTUM    = 2'd0,
    CFG_FLOW_COUNT = 2'd1,
    CFG_FLOW_LIMIT = 2'd2
  } cfg_idx_e;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

endpackage

// ===== rtl/sfq_drr_packet_scheduler_core.sv =====
// SFQ/DRR packet scheduler top: control sequencer, ring memory, config regs.
// Depends on sfq_pkg, sfq_hash_mod, sfq_flow_tbl, sfq_pkt_ram.
// Enqueue steps: S_ERD, S_EUPD, S_RESP; a matched hash first waits in S_DIV for the
// hash reduction. Dequeue: S_DCHK, then S_RESP on an empty ring, else S_DRING, S_DFLOW
// and S_DPKT when a packet is returned, with a pass back through S_DCHK per ring visit
// (rotation or removal of an empty flow). A held result adds its stall.
// Reset: config to defaults, ring empty, flow table reads as zero; no sweep.
`timescale 1ns / 1ps

module sfq_drr_packet_scheduler_core import sfq_pkg::*; #(
  parameter int MAX_FLOWS  = MAX_FLOWS_DEF,
  parameter int FLOW_DEPTH = FLOW_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [HASH_W-1:0]  flow_hash_i,
  input  logic               hash_matched_i,
  input  logic [LEN_W-1:0]   packet_len_i,
  input  logic [TAG_W-1:0]   packet_tag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               enq_accepted_o,
  output logic               deq_valid_o,
  output logic [TAG_W-1:0]   deq_tag_o,
  output logic [LEN_W-1:0]   deq_len_o,
  output logic [FLOW_OW-1:0] deq_flow_o,
  input  logic               cfg_we_i,
  input  logic [CFG_IW-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i
);

  localparam int NFLOWS = MAX_FLOWS + 1;
  localparam int FW     = $clog2(NFLOWS);
  localparam int RCW    = $clog2(NFLOWS + 1);
  localparam int HW     = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1;
  localparam int CW     = $clog2(FLOW_DEPTH + 1);
  localparam int FE_W   = DEF_W + 1 + HW + CW;
  localparam int PDEPTH = NFLOWS * FLOW_DEPTH;
  localparam int AW     = $clog2(PDEPTH);
  localparam int PW     = TAG_W + LEN_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_ERD   = 9'b000000100,
    S_EUPD  = 9'b000001000,
    S_DCHK  = 9'b000010000,
    S_DRING = 9'b000100000,
    S_DFLOW = 9'b001000000,
    S_DPKT  = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [QUANT_W-1:0] quantum_q;
  logic [FC_W-1:0]    flow_count_q;
  logic [LIM_W-1:0]   flow_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q    <= QUANT_RST;
      flow_count_q <= FC_RST;
      flow_limit_q <= LIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_QUANTUM:    quantum_q    <= cfg_wdata_i[QUANT_W-1:0];
        CFG_FLOW_COUNT: flow_count_q <= cfg_wdata_i[FC_W-1:0];
        CFG_FLOW_LIMIT: flow_limit_q <= cfg_wdata_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [QUANT_W-1:0]      q_eff;
  logic signed [DEF_W-1:0] q_def;
  logic [FC_W-1:0]         fc_div;

  assign q_eff  = (quantum_q == '0) ? QUANT_W'(1) : quantum_q;
  assign q_def  = $signed({{(DEF_W-QUANT_W){1'b0}}, q_eff});
  assign fc_div = (flow_count_q == '0) ? FC_W'(1) :
                  ((32'(flow_count_q) > MAX_FLOWS) ? FC_W'(MAX_FLOWS) : flow_count_q);

  // request and working registers
  logic [LEN_W-1:0]        len_q;
  logic [TAG_W-1:0]        tag_q;
  logic [FW-1:0]           f_q, f_d;
  logic signed [DEF_W-1:0] def_q, def_d;
  logic [HW-1:0]           nh_q, nh_d;
  logic [CW-1:0]           nc_q, nc_d;

  logic [FW-1:0]  ring_head_q, ring_head_d;
  logic [FW-1:0]  ring_tail_q, ring_tail_d;
  logic [RCW-1:0] ring_cnt_q, ring_cnt_d;

  logic               res_acc_q, res_acc_d;
  logic               res_dv_q, res_dv_d;
  logic [TAG_W-1:0]   res_tag_q, res_tag_d;
  logic [LEN_W-1:0]   res_len_q, res_len_d;
  logic [FLOW_OW-1:0] res_flow_q, res_flow_d;

  logic               out_valid_q;
  logic               out_acc_q, out_dv_q;
  logic [TAG_W-1:0]   out_tag_q;
  logic [LEN_W-1:0]   out_len_q;
  logic [FLOW_OW-1:0] out_flow_q;

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // remainder unit
  logic            div_start, div_done;
  logic [FC_W-1:0] div_rem;

  assign div_start = in_acc && (cmd_i == CMD_ENQ) && hash_matched_i;

  sfq_hash_mod u_hash_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hash_i  (flow_hash_i),
    .div_i   (fc_div),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  // flow table
  logic            fl_re, fl_we;
  logic [FW-1:0]   fl_raddr;
  logic [FE_W-1:0] fl_rdata, fl_wdata;

  sfq_flow_tbl #(
    .DEPTH (NFLOWS),
    .WIDTH (FE_W)
  ) u_flow_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (fl_re),
    .rd_addr_i (fl_raddr),
    .rd_data_o (fl_rdata),
    .wr_en_i   (fl_we),
    .wr_addr_i (f_q),
    .wr_data_i (fl_wdata)
  );

  logic signed [DEF_W-1:0] fl_def;
  logic                    fl_use;
  logic [HW-1:0]           fl_head;
  logic [CW-1:0]           fl_cnt;

  assign fl_def  = $signed(fl_rdata[FE_W-1 -: DEF_W]);
  assign fl_use  = fl_rdata[HW+CW];
  assign fl_head = fl_rdata[CW +: HW];
  assign fl_cnt  = fl_rdata[CW-1:0];

  // packet store
  logic          pk_re, pk_we;
  logic [AW-1:0] pk_raddr, pk_waddr;
  logic [PW-1:0] pk_rdata;

  sfq_pkt_ram #(
    .DEPTH (PDEPTH),
    .WIDTH (PW)
  ) u_pkt_ram (
    .clk_i     (clk_i),
    .rd_en_i   (pk_re),
    .rd_addr_i (pk_raddr),
    .rd_data_o (pk_rdata),
    .wr_en_i   (pk_we),
    .wr_addr_i (pk_waddr),
    .wr_data_i ({tag_q, len_q})
  );

  // ring of active flows
  logic [FW-1:0] ring_mem [NFLOWS];
  logic [FW-1:0] ring_rd_q;
  logic          ring_re, ring_we;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_tail_q] <= f_q;
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[ring_head_q];
    end
  end

  logic [FW-1:0] head_inc, tail_inc;
  assign head_inc = (ring_head_q == FW'(MAX_FLOWS)) ? '0 : ring_head_q + 1'b1;
  assign tail_inc = (ring_tail_q == FW'(MAX_FLOWS)) ? '0 : ring_tail_q + 1'b1;

  // per-flow FIFO arithmetic
  logic          fifo_full;
  logic [31:0]   slot_sum;
  logic [HW-1:0] slot;
  logic [HW-1:0] fh_inc;

  assign fifo_full = (32'(fl_cnt) >= 32'(flow_limit_q)) || (32'(fl_cnt) >= FLOW_DEPTH);
  assign slot_sum  = 32'(fl_head) + 32'(fl_cnt);
  assign slot      = (slot_sum >= FLOW_DEPTH) ? HW'(slot_sum - FLOW_DEPTH) : HW'(slot_sum);
  assign fh_inc    = (32'(fl_head) + 1 >= FLOW_DEPTH) ? '0 : fl_head + 1'b1;
  assign pk_waddr  = AW'(32'(f_q) * FLOW_DEPTH + 32'(slot));
  assign pk_raddr  = AW'(32'(f_q) * FLOW_DEPTH + 32'(fl_head));
  assign fl_raddr  = (state_q == S_DRING) ? ring_rd_q : f_q;

  logic res_load;
  assign res_load = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    f_d         = f_q;
    def_d       = def_q;
    nh_d        = nh_q;
    nc_d        = nc_q;
    ring_head_d = ring_head_q;
    ring_tail_d = ring_tail_q;
    ring_cnt_d  = ring_cnt_q;
    res_acc_d   = res_acc_q;
    res_dv_d    = res_dv_q;
    res_tag_d   = res_tag_q;
    res_len_d   = res_len_q;
    res_flow_d  = res_flow_q;
    fl_re       = 1'b0;
    fl_we       = 1'b0;
    fl_wdata    = fl_rdata;
    pk_re       = 1'b0;
    pk_we       = 1'b0;
    ring_re     = 1'b0;
    ring_we     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_acc_d  = 1'b0;
          res_dv_d   = 1'b0;
          res_tag_d  = '0;
          res_len_d  = '0;
          res_flow_d = '0;
          if (cmd_i == CMD_DEQ) begin
            state_d = S_DCHK;
          end else if (hash_matched_i) begin
            state_d = S_DIV;
          end else begin
            f_d     = FW'(fc_div);   // extra flow
            state_d = S_ERD;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          f_d     = FW'(div_rem);
          state_d = S_ERD;
        end
      end
      S_ERD: begin
        fl_re   = 1'b1;
        state_d = S_EUPD;
      end
      S_EUPD: begin
        fl_we    = 1'b1;
        fl_wdata = {(fl_use ? fl_def : q_def), 1'b1, fl_head,
                    (fifo_full ? fl_cnt : fl_cnt + 1'b1)};
        if (!fl_use) begin
          ring_we     = 1'b1;
          ring_tail_d = tail_inc;
          ring_cnt_d  = ring_cnt_q + 1'b1;
        end
        pk_we     = !fifo_full;
        res_acc_d = !fifo_full;
        state_d   = S_RESP;
      end
      S_DCHK: begin
        if (ring_cnt_q == '0) begin
          state_d = S_RESP;
        end else begin
          ring_re = 1'b1;
          state_d = S_DRING;
        end
      end
      S_DRING: begin
        f_d     = ring_rd_q;
        fl_re   = 1'b1;
        state_d = S_DFLOW;
      end
      S_DFLOW: begin
        if (fl_def <= 0) begin
          // no credit: top up and rotate to the back
          fl_we       = 1'b1;
          fl_wdata    = {fl_def + q_def, fl_use, fl_head, fl_cnt};
          ring_we     = 1'b1;
          ring_head_d = head_inc;
          ring_tail_d = tail_inc;
          state_d     = S_DCHK;
        end else if (fl_cnt == '0) begin
          // credit but nothing queued: flow goes idle
          fl_we       = 1'b1;
          fl_wdata    = {fl_def, 1'b0, fl_head, fl_cnt};
          ring_head_d = head_inc;
          ring_cnt_d  = ring_cnt_q - 1'b1;
          state_d     = S_DCHK;
        end else begin
          pk_re   = 1'b1;
          def_d   = fl_def;
          nh_d    = fh_inc;
          nc_d    = fl_cnt - 1'b1;
          state_d = S_DPKT;
        end
      end
      S_DPKT: begin
        fl_we      = 1'b1;
        fl_wdata   = {def_q - $signed({{(DEF_W-LEN_W){1'b0}}, pk_rdata[LEN_W-1:0]}),
                      1'b1, nh_q, nc_q};
        res_dv_d   = 1'b1;
        res_tag_d  = pk_rdata[PW-1 -: TAG_W];
        res_len_d  = pk_rdata[LEN_W-1:0];
        res_flow_d = FLOW_OW'(f_q);
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (res_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ring_head_q <= '0;
      ring_tail_q <= '0;
      ring_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ring_head_q <= ring_head_d;
      ring_tail_q <= ring_tail_d;
      ring_cnt_q  <= ring_cnt_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      len_q <= packet_len_i;
      tag_q <= packet_tag_i;
    end
    f_q        <= f_d;
    def_q      <= def_d;
    nh_q       <= nh_d;
    nc_q       <= nc_d;
    res_acc_q  <= res_acc_d;
    res_dv_q   <= res_dv_d;
    res_tag_q  <= res_tag_d;
    res_len_q  <= res_len_d;
    res_flow_q <= res_flow_d;
    if (res_load) begin
      out_acc_q  <= res_acc_q;
      out_dv_q   <= res_dv_q;
      out_tag_q  <= res_tag_q;
      out_len_q  <= res_len_q;
      out_flow_q <= res_flow_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign enq_accepted_o = out_acc_q;
  assign deq_valid_o    = out_dv_q;
  assign deq_tag_o      = out_tag_q;
  assign deq_len_o      = out_len_q;
  assign deq_flow_o     = out_flow_q;

endmodule

// ===== rtl/sfq_hash_mod.sv =====
// Multi-cycle remainder unit: hash mod flow count, DIV_BITS bits per cycle.
// Depends on sfq_pkg.
`timescale 1ns / 1ps

module sfq_hash_mod import sfq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [HASH_W-1:0] hash_i,
  input  logic [FC_W-1:0]   div_i,
  output logic              done_o,
  output logic [FC_W-1:0]   rem_o
);

  localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [HASH_W-1:0] sh_q;
  logic [FC_W-1:0]   rem_q, rem_d;
  logic [FC_W-1:0]   dv_q;

  always_comb begin
    logic [FC_W:0]   t;
    logic [FC_W-1:0] r;
    r = rem_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, sh_q[HASH_W-1-i]};
      if (t >= {1'b0, dv_q}) begin
        r = FC_W'(t - {1'b0, dv_q});
      end else begin
        r = FC_W'(t);
      end
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= hash_i;
      dv_q  <= div_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= sh_q << DIV_BITS;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/sfq_flow_tbl.sv =====
// Per-flow state memory, registered read, with a valid bit per
// entry so that unwritten entries read as zero after reset. No dependencies.
`timescale 1ns / 1ps

module sfq_flow_tbl #(
  parameter int DEPTH = 129,
  parameter int WIDTH = 28
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/sfq_pkt_ram.sv =====
// Packet store: simple dual-port RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sfq_pkt_ram #(
  parameter int DEPTH = 2064,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule
